// File: src/bchc_pkg.sv
// Shared types, codes and helpers for the block chain header checker.
`default_nettype none
package bchc_pkg;

  localparam int OFF_W      = 40;
  localparam int SIZE_W     = 32;
  localparam int CNT_W      = 32;
  localparam int BYTE_W     = 8;
  localparam int HDR_W      = 4;
  localparam int CODE_W     = 3;
  localparam int REG_IDX_W  = 1;
  localparam int REG_DATA_W = 40;
  localparam int DEF_OFFSET_BITS = 40;
  localparam int HDR_LEN    = 16;

  localparam logic [REG_IDX_W-1:0] REG_FILE_LEN   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MORE_FILES = 1'b1;

  typedef enum logic [CODE_W-1:0] {
    EV_BLOCK_OK    = 3'd0,
    EV_ZERO_SIZE   = 3'd1,
    EV_BAD_HEADER  = 3'd2,
    EV_BEYOND_END  = 3'd3,
    EV_TRAILING    = 3'd4,
    EV_FILE_CLEAN  = 3'd5
  } evt_code_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2,
    PH_HALTED  = 2'd3
  } phase_t;

  typedef struct packed {
    evt_code_t          code;
    logic [OFF_W-1:0]   offset;
    logic [SIZE_W-1:0]  size;
    logic [CNT_W-1:0]   count;
    logic               risk;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic is_letter(input logic [BYTE_W-1:0] c);
    return (c >= 8'd65) && (c <= 8'd90);
  endfunction

endpackage
`default_nettype wire

// File: src/bchc_fifo.sv
// Four-entry result queue: takes up to two results per cycle, drains one per beat.
`default_nettype none
module bchc_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire bchc_pkg::push_t  push,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bchc_pkg::result_t     head
);
  import bchc_pkg::*;

  result_t    mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign room      = (count <= 3'd2);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push.n} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.r1;
    end
  end

endmodule
`default_nettype wire

// File: src/bchc_core.sv
// Input register, walker state and per-byte event generation.
`default_nettype none
module bchc_core #(
  parameter int OFFSET_BITS = bchc_pkg::DEF_OFFSET_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [bchc_pkg::REG_IDX_W-1:0]      wr_index,
  input  wire logic [bchc_pkg::REG_DATA_W-1:0]     wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [bchc_pkg::BYTE_W-1:0]         data_byte,
  input  wire logic                                start_of_file,
  input  wire logic                                room,
  output bchc_pkg::push_t                          push
);
  import bchc_pkg::*;

  localparam int CW = (OFFSET_BITS > OFF_W) ? OFFSET_BITS : OFF_W;

  logic [OFF_W-1:0]        file_len;
  logic                    more_files;

  logic                    in_q_valid;
  logic [BYTE_W-1:0]       in_q_data;
  logic                    in_q_sof;
  logic                    go;

  logic [OFFSET_BITS-1:0]  position, position_next;
  logic [HDR_W-1:0]        header_index, header_index_next;
  logic [SIZE_W-1:0]       type_bytes, type_bytes_next;
  logic [SIZE_W-1:0]       size_bytes, size_bytes_next;
  logic [SIZE_W-1:0]       payload_left, payload_left_next;
  logic [CNT_W-1:0]        accepted, accepted_next;
  phase_t                  phase, phase_next;

  phase_t                  ph_e;
  logic [HDR_W-1:0]        hi_e;
  logic [OFFSET_BITS-1:0]  pos_e, pos_new, hpos;
  logic [SIZE_W-1:0]       pl_e, pl_dec;
  logic                    first;

  logic [CW-1:0]           fs_x, bpos_x, bdiff, hpos_x, hdiff;
  logic                    b_clean, b_trail, b_hit;
  result_t                 b_res;

  logic                    type_ok, beyond;
  evt_code_t               hcode;
  result_t                 h_res;

  assign in_stall = in_q_valid && !room;
  assign go       = in_q_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_len   <= '0;
      more_files <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FILE_LEN:   file_len   <= wr_data[OFF_W-1:0];
        REG_MORE_FILES: more_files <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_q_data <= data_byte;
      in_q_sof  <= start_of_file;
    end
  end

  assign ph_e    = in_q_sof ? PH_HEADER : phase;
  assign hi_e    = in_q_sof ? '0 : header_index;
  assign pos_e   = in_q_sof ? '0 : position;
  assign pl_e    = in_q_sof ? '0 : payload_left;
  assign pos_new = pos_e + OFFSET_BITS'(1);
  assign hpos    = pos_e - OFFSET_BITS'(HDR_LEN - 1);
  assign pl_dec  = (pl_e != '0) ? pl_e - SIZE_W'(1) : pl_e;
  assign first   = (ph_e == PH_HEADER) && (hi_e == '0) && (pos_e == '0);

  // boundary check at the current block edge
  assign fs_x    = CW'(file_len);
  assign bpos_x  = first ? CW'(pos_e) : CW'(pos_new);
  assign bdiff   = fs_x - bpos_x;
  assign b_clean = (bpos_x >= fs_x);
  assign b_trail = !b_clean && (bdiff < CW'(HDR_LEN));
  assign b_hit   = b_clean || b_trail;

  always_comb begin
    b_res        = '0;
    b_res.code   = b_clean ? EV_FILE_CLEAN : EV_TRAILING;
    b_res.offset = bpos_x[OFF_W-1:0];
    b_res.size   = b_clean ? '0 : SIZE_W'(bdiff[HDR_W-1:0]);
    b_res.count  = accepted;
    b_res.risk   = b_trail && more_files;
    b_res.last   = 1'b1;
  end

  // header check
  assign hpos_x  = CW'(hpos);
  assign hdiff   = fs_x - hpos_x;
  assign type_ok = is_letter(type_bytes[7:0])   && is_letter(type_bytes[15:8]) &&
                   is_letter(type_bytes[23:16]) && is_letter(type_bytes[31:24]);
  assign beyond  = (hpos_x > fs_x) || (CW'(size_bytes) > hdiff);

  always_comb begin
    if (size_bytes == '0) begin
      hcode = EV_ZERO_SIZE;
    end else if (!type_ok || size_bytes < SIZE_W'(HDR_LEN)) begin
      hcode = EV_BAD_HEADER;
    end else if (beyond) begin
      hcode = EV_BEYOND_END;
    end else begin
      hcode = EV_BLOCK_OK;
    end
  end

  always_comb begin
    h_res        = '0;
    h_res.code   = hcode;
    h_res.offset = OFF_W'(hpos_x);
    h_res.size   = size_bytes;
    h_res.count  = (hcode == EV_BLOCK_OK) ? accepted + CNT_W'(1) : accepted;
    h_res.risk   = 1'b0;
    h_res.last   = 1'b1;
  end

  always_comb begin
    position_next     = position;
    header_index_next = header_index;
    type_bytes_next   = type_bytes;
    size_bytes_next   = size_bytes;
    payload_left_next = payload_left;
    accepted_next     = accepted;
    phase_next        = phase;
    push              = '0;
    if (go && phase != PH_HALTED) begin
      position_next     = pos_e;
      header_index_next = hi_e;
      payload_left_next = pl_e;
      phase_next        = ph_e;
      case (ph_e)
        PH_HEADER: begin
          if (first && b_hit) begin
            push.n     = 2'd1;
            push.r0    = b_res;
            phase_next = PH_DONE;
          end else begin
            if (hi_e < HDR_W'(4)) begin
              type_bytes_next[8*hi_e[1:0] +: 8] = in_q_data;
            end else if (hi_e < HDR_W'(8)) begin
              size_bytes_next[8*hi_e[1:0] +: 8] = in_q_data;
            end
            position_next = pos_new;
            if (hi_e != HDR_W'(HDR_LEN - 1)) begin
              header_index_next = hi_e + HDR_W'(1);
            end else begin
              header_index_next = '0;
              push.n  = 2'd1;
              push.r0 = h_res;
              if (hcode != EV_BLOCK_OK) begin
                phase_next = PH_HALTED;
              end else begin
                accepted_next     = h_res.count;
                payload_left_next = size_bytes - SIZE_W'(HDR_LEN);
                if (size_bytes != SIZE_W'(HDR_LEN)) begin
                  phase_next = PH_PAYLOAD;
                end else if (b_hit) begin
                  push.n        = 2'd2;
                  push.r0.last  = 1'b0;
                  push.r1       = b_res;
                  push.r1.count = h_res.count;
                  phase_next    = PH_DONE;
                end else begin
                  phase_next = PH_HEADER;
                end
              end
            end
          end
        end
        PH_PAYLOAD: begin
          position_next     = pos_new;
          payload_left_next = pl_dec;
          if (pl_dec == '0) begin
            if (b_hit) begin
              push.n     = 2'd1;
              push.r0    = b_res;
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_HEADER;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      header_index <= '0;
      type_bytes   <= '0;
      size_bytes   <= '0;
      payload_left <= '0;
      accepted     <= '0;
      phase        <= PH_HEADER;
    end else begin
      position     <= position_next;
      header_index <= header_index_next;
      type_bytes   <= type_bytes_next;
      size_bytes   <= size_bytes_next;
      payload_left <= payload_left_next;
      accepted     <= accepted_next;
      phase        <= phase_next;
    end
  end

endmodule
`default_nettype wire

// File: src/block_chain_header_checker.sv
// Top level of the block chain header checker.
// Takes one file byte per cycle and walks the chain of 16-byte block headers,
// reporting each checked header and the end of each file as result beats.
// A byte is registered, then checked against the walker state once the queue
// has room, and its results (none, one or two) enter a four-entry result
// queue. Input rate is one byte per cycle; the queue drains one result per
// cycle while out_stall is low. A byte that completes a 16-byte block at the
// file boundary yields two results, and input stalls only while the queue
// lacks room for two results. A zero size, invalid header or block past the
// configured file length halts the checker until reset. Write the file
// length and more_files_follow registers only while no byte is in flight.
`default_nettype none
module block_chain_header_checker #(
  parameter int OFFSET_BITS = bchc_pkg::DEF_OFFSET_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [bchc_pkg::REG_IDX_W-1:0]   wr_index,
  input  wire logic [bchc_pkg::REG_DATA_W-1:0]  wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [bchc_pkg::BYTE_W-1:0]      data_byte,
  input  wire logic                             start_of_file,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [bchc_pkg::CODE_W-1:0]           event_code,
  output logic [bchc_pkg::OFF_W-1:0]            block_offset,
  output logic [bchc_pkg::SIZE_W-1:0]           block_size,
  output logic [bchc_pkg::CNT_W-1:0]            block_count,
  output logic                                  next_file_at_risk,
  output logic                                  last_of_run
);
  import bchc_pkg::*;

  push_t   push;
  logic    room;
  result_t head;

  bchc_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .start_of_file(start_of_file),
    .room         (room),
    .push         (push)
  );

  bchc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign event_code        = head.code;
  assign block_offset      = head.offset;
  assign block_size        = head.size;
  assign block_count       = head.count;
  assign next_file_at_risk = head.risk;
  assign last_of_run       = head.last;

endmodule
`default_nettype wire

// File: bench/block_chain_header_checker_tb.sv
// Testbench for block_chain_header_checker: directed and random block chains checked beat by beat.
`timescale 1ns / 100ps
module block_chain_header_checker_tb;
  import bchc_pkg::*;

  class chain_scoreboard;
    result_t expected_q[$];
    int mismatches;
    logic [OFF_W-1:0] file_len;
    logic more_files;
    logic [OFF_W-1:0] position;
    logic [HDR_W-1:0] hdr_idx;
    logic [31:0] type_word;
    logic [SIZE_W-1:0] size_word;
    logic [SIZE_W-1:0] payload_left;
    logic [CNT_W-1:0] accepted;
    phase_t phase;

    function new();
      mismatches = 0;
      file_len = '0;
      more_files = 1'b0;
      position = '0;
      hdr_idx = '0;
      type_word = '0;
      size_word = '0;
      payload_left = '0;
      accepted = '0;
      phase = PH_HEADER;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] val);
      if (idx == REG_FILE_LEN) file_len = val[OFF_W-1:0];
      else if (idx == REG_MORE_FILES) more_files = val[0];
    endfunction

    function void push_event(evt_code_t c, logic [OFF_W-1:0] off, logic [SIZE_W-1:0] sz,
                             logic risk);
      result_t r;
      r.code = c;
      r.offset = off;
      r.size = sz;
      r.count = accepted;
      r.risk = risk;
      r.last = 1'b0;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void mark_last();
      result_t r;
      r = expected_q.pop_back();
      r.last = 1'b1;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function int check_boundary();
      logic [OFF_W-1:0] gap;
      if (position >= file_len) begin
        push_event(EV_FILE_CLEAN, position, '0, 1'b0);
        phase = PH_DONE;
        return 1;
      end
      gap = file_len - position;
      if (gap < HDR_LEN) begin
        push_event(EV_TRAILING, position, SIZE_W'(gap), more_files);
        phase = PH_DONE;
        return 1;
      end
      phase = PH_HEADER;
      return 0;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic sof);
      logic [OFF_W-1:0] hpos;
      logic letters;
      logic fatal;
      evt_code_t code;
      if (phase == PH_HALTED) return;
      if (sof) begin
        position = '0;
        hdr_idx = '0;
        type_word = '0;
        size_word = '0;
        payload_left = '0;
        phase = PH_HEADER;
      end
      if (phase == PH_DONE) return;
      if (phase == PH_HEADER) begin
        if (hdr_idx == 0 && position == 0) begin
          if (check_boundary() != 0) begin
            mark_last();
            return;
          end
        end
        if (hdr_idx < 4) type_word[8*int'(hdr_idx) +: 8] = b;
        else if (hdr_idx < 8) size_word[8*(int'(hdr_idx)-4) +: 8] = b;
        position = position + OFF_W'(1);
        if (hdr_idx < 15) begin
          hdr_idx = hdr_idx + HDR_W'(1);
          return;
        end
        hdr_idx = '0;
        hpos = position - OFF_W'(HDR_LEN);
        letters = 1'b1;
        for (int i = 0; i < 4; i++)
          if (type_word[8*i +: 8] < 8'd65 || type_word[8*i +: 8] > 8'd90) letters = 1'b0;
        fatal = 1'b1;
        code = EV_BLOCK_OK;
        if (size_word == 0) code = EV_ZERO_SIZE;
        else if (!letters || size_word < HDR_LEN) code = EV_BAD_HEADER;
        else if (hpos > file_len || OFF_W'(size_word) > file_len - hpos) code = EV_BEYOND_END;
        else fatal = 1'b0;
        if (fatal) begin
          push_event(code, hpos, size_word, 1'b0);
          mark_last();
          phase = PH_HALTED;
          return;
        end
        accepted = accepted + CNT_W'(1);
        push_event(EV_BLOCK_OK, hpos, size_word, 1'b0);
        payload_left = size_word - SIZE_W'(HDR_LEN);
        if (payload_left == 0) void'(check_boundary());
        else phase = PH_PAYLOAD;
        mark_last();
        return;
      end
      position = position + OFF_W'(1);
      if (payload_left > 0) payload_left = payload_left - SIZE_W'(1);
      if (payload_left == 0)
        if (check_boundary() != 0) mark_last();
    endfunction

    function void check_result(logic [CODE_W-1:0] code, logic [OFF_W-1:0] off,
                               logic [SIZE_W-1:0] sz, logic [CNT_W-1:0] cnt,
                               logic risk, logic last);
      result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t unexpected beat: code %0d off %0h size %0h count %0d risk %b last %b",
                   $time, code, off, sz, cnt, risk, last);
        return;
      end
      e = expected_q.pop_front();
      if (e.code !== code || e.offset !== off || e.size !== sz || e.count !== cnt ||
          e.risk !== risk || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t expected: code %0d off %0h size %0h count %0d risk %b last %b",
                   $time, e.code, e.offset, e.size, e.count, e.risk, e.last);
          $display("%0t actual:   code %0d off %0h size %0h count %0d risk %b last %b",
                   $time, code, off, sz, cnt, risk, last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [REG_DATA_W-1:0] wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] data_byte = '0;
  logic start_of_file = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CODE_W-1:0] event_code;
  logic [OFF_W-1:0] block_offset;
  logic [SIZE_W-1:0] block_size;
  logic [CNT_W-1:0] block_count;
  logic next_file_at_risk;
  logic last_of_run;

  chain_scoreboard sb = new();
  logic no_gaps = 1'b0;
  logic hold_req = 1'b0;
  logic sof_pending = 1'b0;
  logic [BYTE_W-1:0] hdr_bytes[HDR_LEN];
  int bytes_sent = 0;

  block_chain_header_checker dut (
    .clk(clk),
    .rst(rst),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .start_of_file(start_of_file),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_code(event_code),
    .block_offset(block_offset),
    .block_size(block_size),
    .block_count(block_count),
    .next_file_at_risk(next_file_at_risk),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    logic sof;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    sof = sof_pending;
    sof_pending = 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_of_file <= sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b, sof);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_config(input logic [OFF_W-1:0] fs, input logic more);
    logic [REG_DATA_W-1:0] v;
    v = REG_DATA_W'({$urandom, $urandom});
    v[0] = more;
    wr_en <= 1'b1;
    wr_index <= REG_FILE_LEN;
    wr_data <= fs;
    @(posedge clk);
    sb.set_reg(REG_FILE_LEN, fs);
    wr_index <= REG_MORE_FILES;
    wr_data <= v;
    @(posedge clk);
    sb.set_reg(REG_MORE_FILES, v);
    wr_en <= 1'b0;
  endtask

  task automatic begin_file(input logic [OFF_W-1:0] fs, input logic more);
    settle();
    write_config(fs, more);
    no_gaps = ($urandom_range(0, 3) == 0);
    sof_pending = 1'b1;
  endtask

  function automatic logic [31:0] random_type();
    logic [31:0] tw;
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 5))
        0: tw[8*i +: 8] = 8'd65;
        1: tw[8*i +: 8] = 8'd90;
        default: tw[8*i +: 8] = 8'($urandom_range(65, 90));
      endcase
    end
    return tw;
  endfunction

  function automatic int pick_size();
    if ($urandom_range(0, 5) == 0) return HDR_LEN;
    if ($urandom_range(0, 19) == 0) return $urandom_range(41, 200);
    return $urandom_range(16, 40);
  endfunction

  function automatic void fill_header(input logic [31:0] tw, input logic [SIZE_W-1:0] sz);
    for (int i = 0; i < 4; i++) begin
      hdr_bytes[i] = tw[8*i +: 8];
      hdr_bytes[i+4] = sz[8*i +: 8];
    end
    for (int i = 8; i < HDR_LEN; i++) hdr_bytes[i] = 8'($urandom);
  endfunction

  task automatic send_block(input int sz, input logic [31:0] tw);
    fill_header(tw, SIZE_W'(sz));
    for (int i = 0; i < HDR_LEN; i++) send_byte(hdr_bytes[i]);
    repeat (sz - HDR_LEN) send_byte(8'($urandom));
  endtask

  task automatic run_file();
    int kind, nblk, trail, total, s, k;
    int sizes[$];
    logic more;
    kind = $urandom_range(0, 9);
    nblk = $urandom_range(1, 4);
    total = 0;
    for (int i = 0; i < nblk; i++) begin
      sizes.insert(i, pick_size());
      total += sizes[i];
    end
    trail = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
    more = 1'($urandom_range(0, 1));
    if (kind <= 5) begin
      begin_file(OFF_W'(total + trail), more);
      foreach (sizes[i]) send_block(sizes[i], random_type());
      repeat (trail + $urandom_range(0, 2)) send_byte(8'($urandom));
    end else if (kind <= 7) begin
      begin_file(kind == 6 ? {OFF_W{1'b1}} : OFF_W'(total + $urandom_range(16, 1000)), more);
      foreach (sizes[i]) send_block(sizes[i], random_type());
      if ($urandom_range(0, 1) == 1) repeat ($urandom_range(1, 15)) send_byte(8'($urandom));
    end else if (kind == 8) begin
      s = $urandom_range(18, 60);
      begin_file(OFF_W'(s + trail), more);
      fill_header(random_type(), SIZE_W'(s));
      for (int i = 0; i < HDR_LEN; i++) send_byte(hdr_bytes[i]);
      k = $urandom_range(1, s - 17);
      repeat (k) send_byte(8'($urandom));
      settle();
      write_config(OFF_W'($urandom_range(0, 16 + k)), more);
      repeat (s - HDR_LEN - k) send_byte(8'($urandom));
    end else begin
      begin_file(OFF_W'($urandom_range(0, 15)), more);
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
    end
  endtask

  task automatic run_pressure();
    begin_file(OFF_W'(20 * HDR_LEN), 1'b1);
    no_gaps = 1'b1;
    hold_req = 1'b1;
    repeat (20) send_block(HDR_LEN, random_type());
  endtask

  task automatic run_fatal();
    int kind, pos;
    logic [31:0] tw;
    logic [SIZE_W-1:0] sz;
    logic [OFF_W-1:0] fs;
    kind = $urandom_range(0, 4);
    tw = random_type();
    fs = OFF_W'($urandom_range(64, 300));
    case (kind)
      0: begin
        sz = '0;
        if ($urandom_range(0, 1) == 1) tw = $urandom;
      end
      1: begin
        sz = SIZE_W'($urandom_range(16, 60));
        pos = $urandom_range(0, 3);
        tw[8*pos +: 8] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 64))
                                                      : 8'($urandom_range(91, 255));
      end
      2: sz = SIZE_W'($urandom_range(1, 15));
      default: begin
        fs = OFF_W'($urandom_range(16, 200));
        sz = ($urandom_range(0, 1) == 1) ? {SIZE_W{1'b1}} : SIZE_W'(fs) + SIZE_W'($urandom_range(1, 50));
      end
    endcase
    if (kind == 4) begin
      begin_file(OFF_W'(1000), 1'b0);
      send_block(HDR_LEN, random_type());
      fill_header(random_type(), SIZE_W'(32));
      for (int i = 0; i < 5; i++) send_byte(hdr_bytes[i]);
      settle();
      write_config(OFF_W'($urandom_range(0, 15)), 1'b0);
      for (int i = 5; i < HDR_LEN; i++) send_byte(hdr_bytes[i]);
    end else begin
      begin_file(fs, 1'($urandom_range(0, 1)));
      fill_header(tw, sz);
      for (int i = 0; i < HDR_LEN; i++) send_byte(hdr_bytes[i]);
    end
    repeat (12) begin
      sof_pending = 1'($urandom_range(0, 1));
      send_byte(8'($urandom));
    end
  endtask

  initial begin : result_sink
    int pause;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
      end
      pause = no_gaps ? 0 : $urandom_range(0, 6);
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(event_code, block_offset, block_size, block_count,
                      next_file_at_risk, last_of_run);
    end
  end

  initial begin : byte_source
    logic pressure_done;
    pressure_done = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    begin_file('0, 1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    begin_file(OFF_W'(7), 1'b1);
    send_byte(8'hFF);
    begin_file(OFF_W'(15), 1'b0);
    send_byte(8'h5A);
    begin_file(OFF_W'(HDR_LEN), 1'b1);
    send_block(HDR_LEN, {8'd65, 8'd90, 8'd90, 8'd65});

    while (bytes_sent < 900) begin
      if (!pressure_done && bytes_sent >= 400) begin
        run_pressure();
        pressure_done = 1'b1;
      end else begin
        run_file();
      end
    end
    run_fatal();

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
src/bchc_pkg.sv
src/bchc_fifo.sv
src/bchc_core.sv
src/block_chain_header_checker.sv
bench/block_chain_header_checker_tb.sv
